>>> rtl/tfm_pkg.sv
// Shared constants, types and helper function of the Tenengrad focus measure block.
`default_nettype none

package tfm_pkg;

  // Fixed widths of the data path
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned CFG_DATA_W     = 12;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned SUM_W          = 43;
  localparam int unsigned MEAN_W         = 29;
  localparam int unsigned FRAC_W         = 8;
  localparam int unsigned DIV_W          = SUM_W + FRAC_W;
  localparam int unsigned GRAD_W         = 11;
  localparam int unsigned SQ_W           = 20;
  localparam int unsigned MIN_DIM        = 3;
  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;
  localparam int unsigned RESET_WIDTH    = 640;
  localparam int unsigned RESET_HEIGHT   = 480;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } tfm_cfg_idx_e;

  // Divider sequencer states
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } tfm_div_state_e;

  // Side information that travels with each pixel down the pipeline
  typedef struct packed {
    logic vld;
    logic interior;
    logic last;
  } tfm_tag_t;

  // Saturate a frame dimension to the range MIN_DIM..hi.
  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned hi);
    int unsigned val;
    val = int'(v);
    if (val < MIN_DIM) begin
      return MIN_DIM;
    end
    if (val > hi) begin
      return hi;
    end
    return val;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tfm_window.sv
// Two-row line memory, 3x3 window and Sobel gradient stage.
`default_nettype none

module tfm_window import tfm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [ADDR_W-1:0]        addr_i,
  input  wire logic [PIX_W-1:0]         pixel_i,
  input  wire tfm_tag_t                 tag_i,
  output logic signed [GRAD_W-1:0]      gx_o,
  output logic signed [GRAD_W-1:0]      gy_o,
  output tfm_tag_t                      tag_o
);

  // One entry per column: upper byte is row r-2, lower byte is row r-1.
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [PIX_W-1:0]   px_q;
  tfm_tag_t           tag_q;

  logic [PIX_W-1:0]   top, mid;
  logic [PIX_W-1:0]   c1_q [3];
  logic [PIX_W-1:0]   c2_q [3];

  logic [PIX_W+1:0]   sum_right, sum_left, sum_lower, sum_upper;
  logic signed [GRAD_W-1:0] gx_d, gy_d;
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  tfm_tag_t           tag_out_q;

  // Line memory: read when a pixel is taken, write back in the following cycle.
  // The same column is read again only a full row later, so no overlap arises.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
      addr_q  <= addr_i;
      px_q    <= pixel_i;
    end
    if (tag_q.vld) begin
      mem[addr_q] <= {mid, px_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign top = rdata_q[2*PIX_W-1:PIX_W];
  assign mid = rdata_q[PIX_W-1:0];

  // Window columns: c1 becomes the left column and c2 the centre column.
  always_ff @(posedge clk_i) begin
    if (tag_q.vld) begin
      c1_q <= c2_q;
      c2_q[0] <= top;
      c2_q[1] <= mid;
      c2_q[2] <= px_q;
    end
  end

  // Sobel gradients from the shifted window (rows 0..2 top to bottom).
  always_comb begin
    sum_right = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, px_q};
    sum_left  = {2'b00, c1_q[0]} + {1'b0, c1_q[1], 1'b0} + {2'b00, c1_q[2]};
    sum_lower = {2'b00, c1_q[2]} + {1'b0, c2_q[2], 1'b0} + {2'b00, px_q};
    sum_upper = {2'b00, c1_q[0]} + {1'b0, c2_q[0], 1'b0} + {2'b00, top};
    gx_d = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
    gy_d = $signed({1'b0, sum_lower}) - $signed({1'b0, sum_upper});
  end

  always_ff @(posedge clk_i) begin
    if (tag_q.vld) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_out_q <= '0;
    end else begin
      tag_out_q <= tag_q;
    end
  end

  assign gx_o  = gx_q;
  assign gy_o  = gy_q;
  assign tag_o = tag_out_q;

endmodule

`default_nettype wire

>>> rtl/tfm_energy.sv
// Squaring stage and frame energy accumulator.
`default_nettype none

module tfm_energy import tfm_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    clear_i,
  input  wire logic signed [GRAD_W-1:0] gx_i,
  input  wire logic signed [GRAD_W-1:0] gy_i,
  input  wire tfm_tag_t                tag_i,
  output logic                         fin_vld_o,
  output logic [SUM_W-1:0]             fin_sum_o
);

  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [SQ_W-1:0]            sqx_q, sqy_q;
  tfm_tag_t                   tag_q;
  logic [SUM_W-1:0]           acc_q, acc_d;
  logic [SQ_W:0]              energy;

  assign gx_sq = (2*GRAD_W)'(gx_i) * (2*GRAD_W)'(gx_i);
  assign gy_sq = (2*GRAD_W)'(gy_i) * (2*GRAD_W)'(gy_i);

  // Register both squares before they are added in.
  always_ff @(posedge clk_i) begin
    if (tag_i.vld) begin
      sqx_q <= gx_sq[SQ_W-1:0];
      sqy_q <= gy_sq[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  // Accumulate interior pixels; the sum wraps at its width.
  always_comb begin
    energy = {1'b0, sqx_q} + {1'b0, sqy_q};
    acc_d  = acc_q;
    if (tag_q.vld && tag_q.interior) begin
      acc_d = acc_q + SUM_W'(energy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (clear_i || (tag_q.vld && tag_q.last)) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign fin_vld_o = tag_q.vld && tag_q.last;
  assign fin_sum_o = acc_d;

endmodule

`default_nettype wire

>>> rtl/tfm_divider.sv
// Restoring divider that forms the fixed-point mean, one quotient bit per cycle.
`default_nettype none

module tfm_divider import tfm_pkg::*; #(
  parameter int unsigned CNT_W = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SUM_W-1:0]   sum_i,
  input  wire logic [CNT_W-1:0]   count_i,
  input  wire logic               ack_i,
  output logic                    done_o,
  output logic [SUM_W-1:0]        sum_o,
  output logic [MEAN_W-1:0]       mean_o
);

  localparam int unsigned STEP_W = $clog2(DIV_W);

  tfm_div_state_e     state_q, state_d;
  logic [STEP_W-1:0]  step_q;
  logic [DIV_W-1:0]   dvd_q;
  logic [CNT_W-1:0]   rem_q;
  logic [CNT_W-1:0]   div_q;
  logic [MEAN_W-1:0]  quo_q;
  logic [SUM_W-1:0]   sum_q;

  logic [CNT_W:0]     trial;
  logic               fits;
  logic               load, step, last_step;

  assign trial     = {rem_q, dvd_q[DIV_W-1]};
  assign fits      = trial >= {1'b0, div_q};
  assign last_step = step_q == STEP_W'(DIV_W - 1);

  // Sequencer
  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    step    = 1'b0;
    done_o  = 1'b0;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          load    = 1'b1;
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        step = 1'b1;
        if (last_step) begin
          state_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        done_o = 1'b1;
        if (ack_i) begin
          state_d = DIV_IDLE;
        end
      end
      default: begin
        state_d = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Data path: the quotient keeps only its low bits as it shifts in.
  always_ff @(posedge clk_i) begin
    if (load) begin
      dvd_q  <= {sum_i, FRAC_W'(0)};
      rem_q  <= '0;
      div_q  <= count_i;
      sum_q  <= sum_i;
      step_q <= '0;
    end else if (step) begin
      dvd_q  <= {dvd_q[DIV_W-2:0], 1'b0};
      rem_q  <= fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
      quo_q  <= {quo_q[MEAN_W-2:0], fits};
      step_q <= step_q + STEP_W'(1);
    end
  end

  assign sum_o  = sum_q;
  assign mean_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/tenengrad_focus_measure_top.sv
// Top level of the Tenengrad focus measure: configuration, frame counters and result register.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | in_valid_i / in_ready_o   | pixel_i
//  out     | output    | out_valid_o / out_ready_i | energy_sum_o, energy_mean_q8_o
//  cfg     | input     | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// Within a frame one pixel is taken every cycle; the line memory is read when a
// pixel is taken and written back on the next cycle.
// After the last pixel of a frame in_ready_o stays low while the result passes three
// pipeline stages, the 51 steps of the bit-serial divider and the hand-over from its done state.
// It stays low longer while the previous result waits in the output register.
// After reset no clearing pass is needed; the line memory is filled before it is used.
`default_nettype none

module tenengrad_focus_measure_top import tfm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [PIX_W-1:0]      pixel_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [SUM_W-1:0]           energy_sum_o,
  output logic [MEAN_W-1:0]          energy_mean_q8_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CNT_W = WW + HW;

  logic [WW-1:0]    w_q, w_d;
  logic [HW-1:0]    h_q, h_d;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [WW-1:0]    wm2;
  logic [HW-1:0]    hm2;
  logic [CNT_W-1:0] count_q;
  logic             busy_q;
  logic             accept, col_last, row_last;
  tfm_tag_t         tag_in, tag_grad;

  logic signed [GRAD_W-1:0] gx, gy;
  logic             fin_vld;
  logic [SUM_W-1:0] fin_sum;
  logic             div_done, div_ack;
  logic [SUM_W-1:0] div_sum;
  logic [MEAN_W-1:0] div_mean;

  logic             out_vld_q;
  logic [SUM_W-1:0] out_sum_q;
  logic [MEAN_W-1:0] out_mean_q;

  // Configuration decode; stored values are already saturated.
  always_comb begin
    w_d = w_q;
    h_d = h_q;
    if (cfg_we_i) begin
      case (tfm_cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  w_d = WW'(clamp_dim(cfg_data_i, MAX_WIDTH));
        CFG_FRAME_HEIGHT: h_d = HW'(clamp_dim(cfg_data_i, MAX_HEIGHT));
        default: begin
          w_d = w_q;
          h_d = h_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WW'(clamp_dim(CFG_DATA_W'(RESET_WIDTH), MAX_WIDTH));
      h_q <= HW'(clamp_dim(CFG_DATA_W'(RESET_HEIGHT), MAX_HEIGHT));
    end else begin
      w_q <= w_d;
      h_q <= h_d;
    end
  end

  // Interior pixel count, settled long before the division needs it.
  assign wm2 = w_q - WW'(2);
  assign hm2 = h_q - HW'(2);

  always_ff @(posedge clk_i) begin
    count_q <= CNT_W'(wm2) * CNT_W'(hm2);
  end

  // Raster position of the incoming pixel
  assign accept   = in_valid_i && in_ready_o;
  assign col_last = (WW'(col_q) + WW'(1)) == w_q;
  assign row_last = (HW'(row_q) + HW'(1)) == h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  assign tag_in.vld      = accept;
  assign tag_in.interior = (col_q >= CW'(2)) && (row_q >= RW'(2));
  assign tag_in.last     = col_last && row_last;

  // Input is held off from the last pixel of a frame until its result is handed over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept && tag_in.last) begin
      busy_q <= 1'b1;
    end else if (div_ack) begin
      busy_q <= 1'b0;
    end
  end

  assign in_ready_o = !busy_q;

  tfm_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .addr_i  (col_q),
    .pixel_i (pixel_i),
    .tag_i   (tag_in),
    .gx_o    (gx),
    .gy_o    (gy),
    .tag_o   (tag_grad)
  );

  tfm_energy u_energy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_we_i),
    .gx_i      (gx),
    .gy_i      (gy),
    .tag_i     (tag_grad),
    .fin_vld_o (fin_vld),
    .fin_sum_o (fin_sum)
  );

  tfm_divider #(
    .CNT_W (CNT_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fin_vld),
    .sum_i   (fin_sum),
    .count_i (count_q),
    .ack_i   (div_ack),
    .done_o  (div_done),
    .sum_o   (div_sum),
    .mean_o  (div_mean)
  );

  // Output register: takes a finished result once the previous transaction has gone.
  assign div_ack = div_done && (!out_vld_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (div_ack) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ack) begin
      out_sum_q  <= div_sum;
      out_mean_q <= div_mean;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign energy_sum_o     = out_sum_q;
  assign energy_mean_q8_o = out_mean_q;

endmodule

`default_nettype wire
